// ===== rtl/core/ftwm_pkg.sv =====
`default_nettype none
// ============================================================================
// ftwm_pkg: shared constants and types for the frame time window monitor
// Field widths, arithmetic constants and the request/response structs
// passed between the serial units and the top level.
// ============================================================================
package ftwm_pkg;

    localparam int STAMP_W   = 64;
    localparam int HZ_W      = 32;
    localparam int DELTA_W   = 40;
    localparam int ELAPSED_W = 64;
    localparam int RATE_W    = 32;
    localparam int WINDOW    = 120;
    localparam int POS_W     = $clog2(WINDOW);
    localparam int SUM_W     = DELTA_W + POS_W;

    // 1e9 fits in 30 bits; the multiplier walks these bits one per cycle
    localparam int NSPS_W = 30;
    localparam logic [NSPS_W-1:0] NS_PER_S = 30'd1000000000;
    localparam int PROD_W = STAMP_W + NSPS_W;

    localparam int CONV_CNT_W  = $clog2(DELTA_W);
    localparam int STATS_CNT_W = $clog2(SUM_W);

    localparam logic [HZ_W-1:0]      HZ_RESET    = 32'd10000000;
    localparam logic [DELTA_W-1:0]   DELTA_MAX   = '1;
    localparam logic [RATE_W-1:0]    RATE_MAX    = '1;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // frame rate numerator: 1e9 * WINDOW * 2^16
    localparam logic [63:0] RATE_NUM = 64'd1000000000 * 64'(WINDOW) * 64'd65536;
    localparam logic [SUM_W-1:0]  RATE_NUM_HI = SUM_W'(RATE_NUM >> RATE_W);
    localparam logic [RATE_W-1:0] RATE_NUM_LO = RATE_NUM[RATE_W-1:0];
    localparam logic [POS_W:0]    WINDOW_C    = (POS_W+1)'(WINDOW);

    typedef struct packed {
        logic               done;
        logic [DELTA_W-1:0] ns;
    } conv_rsp_t;

    typedef struct packed {
        logic               start;
        logic [DELTA_W-1:0] delta;
    } ring_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] sum;
    } ring_rsp_t;

    typedef struct packed {
        logic               done;
        logic [DELTA_W-1:0] avg;
        logic [RATE_W-1:0]  rate;
    } stats_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/ftwm_ifs.sv =====
`default_nettype none
// ============================================================================
// ftwm_ifs: channel interfaces of the frame time window monitor
// Stamp input, report output and counter frequency write channel.
// ============================================================================
interface ftwm_stamp_if;
    import ftwm_pkg::*;
    logic               valid;
    logic               ready;
    logic [STAMP_W-1:0] counter_value;

    modport source (output valid, output counter_value, input ready);
    modport sink   (input valid, input counter_value, output ready);
endinterface

interface ftwm_report_if;
    import ftwm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [DELTA_W-1:0]   delta_ns;
    logic [ELAPSED_W-1:0] elapsed_ns;
    logic [DELTA_W-1:0]   avg_frame_ns;
    logic [RATE_W-1:0]    frame_rate_q16;

    modport source (output valid, output delta_ns, output elapsed_ns,
                    output avg_frame_ns, output frame_rate_q16, input ready);
    modport sink   (input valid, input delta_ns, input elapsed_ns,
                    input avg_frame_ns, input frame_rate_q16, output ready);
endinterface

interface ftwm_cfg_if;
    import ftwm_pkg::*;
    logic            valid;
    logic            ready;
    logic [HZ_W-1:0] counter_hz;

    modport source (output valid, output counter_hz, input ready);
    modport sink   (input valid, input counter_hz, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ftwm_ns_conv.sv =====
`default_nettype none
// ============================================================================
// ftwm_ns_conv: counter difference to nanoseconds
// Bit-serial shift-add multiply by 1e9, a saturation check, then a
// restoring division by the counter frequency, one quotient bit a cycle.
// ============================================================================
module ftwm_ns_conv (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ftwm_pkg::STAMP_W-1:0] diff,
    input  logic [ftwm_pkg::HZ_W-1:0]    hz,
    output ftwm_pkg::conv_rsp_t          rsp
);
    import ftwm_pkg::*;

    typedef enum logic [3:0] {
        CV_IDLE = 4'b0001,
        CV_MUL  = 4'b0010,
        CV_CHK  = 4'b0100,
        CV_DIV  = 4'b1000
    } conv_state_t;

    conv_state_t            state_reg;
    logic [STAMP_W-1:0]     diff_reg;
    logic [PROD_W:0]        prod_reg;
    logic [CONV_CNT_W-1:0]  cnt_reg;
    logic [HZ_W-1:0]        rem_reg;
    logic [DELTA_W-1:0]     quo_reg;
    logic                   sat_reg;
    logic                   done_reg;

    logic [STAMP_W:0]       hi_sum;
    logic [PROD_W:0]        prod_next;
    logic                   over;
    logic [HZ_W:0]          trial;
    logic [HZ_W:0]          trial_sub;
    logic                   take;
    logic [HZ_W-1:0]        rem_next;

    // multiplier bits leave at the bottom, partial sum enters at the top
    assign hi_sum    = prod_reg[PROD_W:NSPS_W]
                     + (prod_reg[0] ? {1'b0, diff_reg} : '0);
    assign prod_next = {1'b0, hi_sum, prod_reg[NSPS_W-1:1]};

    // quotient >= 2^DELTA_W exactly when the product's top part reaches hz
    assign over = prod_reg[PROD_W-1:DELTA_W]
                >= {{(PROD_W-DELTA_W-HZ_W){1'b0}}, hz};

    assign trial     = {rem_reg, quo_reg[DELTA_W-1]};
    assign trial_sub = trial - {1'b0, hz};
    assign take      = trial >= {1'b0, hz};
    assign rem_next  = take ? trial_sub[HZ_W-1:0] : trial[HZ_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= ((state_reg == CV_CHK) && over)
                     || ((state_reg == CV_DIV) && (cnt_reg == CONV_CNT_W'(DELTA_W-1)));
            case (state_reg)
                CV_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= CV_MUL;
                    end
                end
                CV_MUL:
                begin
                    if (cnt_reg == CONV_CNT_W'(NSPS_W-1))
                    begin
                        state_reg <= CV_CHK;
                    end
                end
                CV_CHK:
                begin
                    if (over)
                    begin
                        state_reg <= CV_IDLE;
                    end
                    else
                    begin
                        state_reg <= CV_DIV;
                    end
                end
                CV_DIV:
                begin
                    if (cnt_reg == CONV_CNT_W'(DELTA_W-1))
                    begin
                        state_reg <= CV_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= CV_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            CV_IDLE:
            begin
                if (start)
                begin
                    diff_reg <= diff;
                    prod_reg <= {{(PROD_W+1-NSPS_W){1'b0}}, NS_PER_S};
                    cnt_reg  <= '0;
                end
            end
            CV_MUL:
            begin
                prod_reg <= prod_next;
                cnt_reg  <= cnt_reg + 1'b1;
            end
            CV_CHK:
            begin
                sat_reg <= over;
                rem_reg <= prod_reg[DELTA_W+HZ_W-1:DELTA_W];
                quo_reg <= prod_reg[DELTA_W-1:0];
                cnt_reg <= '0;
            end
            CV_DIV:
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[DELTA_W-2:0], take};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.ns   = sat_reg ? DELTA_MAX : quo_reg;

endmodule
`default_nettype wire

// ===== rtl/core/ftwm_ring.sv =====
`default_nettype none
// ============================================================================
// ftwm_ring: window of frame deltas with running sum
// Single-port delta memory with per-entry valid bits; an update reads the
// oldest entry, subtracts it from the sum, then adds and stores the new one.
// ============================================================================
module ftwm_ring (
    input  logic                clk,
    input  logic                rst_n,
    input  ftwm_pkg::ring_req_t req,
    output ftwm_pkg::ring_rsp_t rsp
);
    import ftwm_pkg::*;

    typedef enum logic [2:0] {
        RG_IDLE = 3'b001,
        RG_SUB  = 3'b010,
        RG_ADD  = 3'b100
    } ring_state_t;

    logic [DELTA_W-1:0] mem [WINDOW];

    ring_state_t        state_reg;
    logic [WINDOW-1:0]  vld_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [DELTA_W-1:0] rd_reg;
    logic               done_reg;

    logic [DELTA_W-1:0] old_delta;
    logic               wr_en;
    logic [POS_W-1:0]   pos_next;

    // entries never written since reset count as zero
    assign old_delta = vld_reg[pos_reg] ? rd_reg : '0;
    assign wr_en     = (state_reg == RG_ADD);
    assign pos_next  = (pos_reg == POS_W'(WINDOW-1)) ? '0 : pos_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pos_reg] <= req.delta;
        end
        rd_reg <= mem[pos_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RG_IDLE;
            vld_reg   <= '0;
            pos_reg   <= '0;
            sum_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == RG_ADD);
            case (state_reg)
                RG_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg <= RG_SUB;
                    end
                end
                RG_SUB:
                begin
                    sum_reg   <= sum_reg - {{POS_W{1'b0}}, old_delta};
                    state_reg <= RG_ADD;
                end
                RG_ADD:
                begin
                    sum_reg          <= sum_reg + {{POS_W{1'b0}}, req.delta};
                    vld_reg[pos_reg] <= 1'b1;
                    pos_reg          <= pos_next;
                    state_reg        <= RG_IDLE;
                end
                default:
                begin
                    state_reg <= RG_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.sum  = sum_reg;

endmodule
`default_nettype wire

// ===== rtl/core/ftwm_stats.sv =====
`default_nettype none
// ============================================================================
// ftwm_stats: window average and frame rate
// Two restoring dividers run side by side, one bit a cycle: window sum by
// the window length, and the Q16.16 rate numerator by the window sum.
// ============================================================================
module ftwm_stats (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ftwm_pkg::SUM_W-1:0]  sum,
    output ftwm_pkg::stats_rsp_t        rsp
);
    import ftwm_pkg::*;

    typedef enum logic [1:0] {
        SS_IDLE = 2'b01,
        SS_RUN  = 2'b10
    } stats_state_t;

    stats_state_t           state_reg;
    logic [STATS_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]       div_reg;
    logic [SUM_W-1:0]       aq_reg;
    logic [POS_W-1:0]       arem_reg;
    logic [SUM_W-1:0]       rrem_reg;
    logic [RATE_W-1:0]      rq_reg;
    logic                   rsat_reg;
    logic                   done_reg;

    logic [POS_W:0]   atrial;
    logic [POS_W:0]   atrial_sub;
    logic             atake;
    logic [POS_W-1:0] arem_next;
    logic [SUM_W:0]   rtrial;
    logic [SUM_W:0]   rtrial_sub;
    logic             rtake;
    logic [SUM_W-1:0] rrem_next;

    assign atrial     = {arem_reg, aq_reg[SUM_W-1]};
    assign atrial_sub = atrial - WINDOW_C;
    assign atake      = atrial >= WINDOW_C;
    assign arem_next  = atake ? atrial_sub[POS_W-1:0] : atrial[POS_W-1:0];

    assign rtrial     = {rrem_reg, rq_reg[RATE_W-1]};
    assign rtrial_sub = rtrial - {1'b0, div_reg};
    assign rtake      = rtrial >= {1'b0, div_reg};
    assign rrem_next  = rtake ? rtrial_sub[SUM_W-1:0] : rtrial[SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == SS_RUN) && (cnt_reg == STATS_CNT_W'(SUM_W-1));
            case (state_reg)
                SS_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= SS_RUN;
                    end
                end
                SS_RUN:
                begin
                    if (cnt_reg == STATS_CNT_W'(SUM_W-1))
                    begin
                        state_reg <= SS_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= SS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            SS_IDLE:
            begin
                if (start)
                begin
                    div_reg  <= sum;
                    aq_reg   <= sum;
                    arem_reg <= '0;
                    rrem_reg <= RATE_NUM_HI;
                    rq_reg   <= RATE_NUM_LO;
                    // quotient would reach 2^32, or sum is zero
                    rsat_reg <= (sum == '0) || (sum <= RATE_NUM_HI);
                    cnt_reg  <= '0;
                end
            end
            SS_RUN:
            begin
                aq_reg   <= {aq_reg[SUM_W-2:0], atake};
                arem_reg <= arem_next;
                if (cnt_reg < STATS_CNT_W'(RATE_W))
                begin
                    rq_reg   <= {rq_reg[RATE_W-2:0], rtake};
                    rrem_reg <= rrem_next;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.avg  = aq_reg[DELTA_W-1:0];
    assign rsp.rate = rsat_reg ? RATE_MAX : rq_reg;

endmodule
`default_nettype wire

// ===== rtl/core/frame_time_window_monitor_top.sv =====
`default_nettype none
// ============================================================================
// frame_time_window_monitor_top: frame timing over a moving window
// Converts per-frame counter stamps to frame delta, elapsed time, window
// average and frame rate.
// ============================================================================
// Usage:
//   stamp  : one free-running counter value per frame (valid/ready).
//   report : delta_ns, elapsed_ns, avg_frame_ns, frame_rate_q16 (valid/ready).
//   cfg    : counter_hz write, always ready; write only while idle.
// The first stamp after reset only sets the reference and gives no report.
// Each later stamp produces one report, computed in order by a bit-serial
// multiply by 1e9, a saturation check, a restoring division by counter_hz,
// the window memory update and the average/rate dividers. A saturated delta
// skips the division. One stamp is in flight at a time: the next stamp is
// accepted only after the current report has been loaded.
// The report sits in an output register; the next stamp is accepted while it
// waits. If the receiver stalls for a full item, the block holds the new
// result until the register frees.
// Reset clears the window (valid bits, no sweep), elapsed time and
// reference, and sets counter_hz to 10000000.
// ============================================================================
module frame_time_window_monitor_top (
    input  logic                 clk,
    input  logic                 rst_n,
    ftwm_stamp_if.sink           stamp,
    ftwm_report_if.source        report,
    ftwm_cfg_if.sink             cfg
);
    import ftwm_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CONV  = 5'b00010,
        ST_RING  = 5'b00100,
        ST_STATS = 5'b01000,
        ST_OUT   = 5'b10000
    } top_state_t;

    top_state_t           state_reg;
    logic [HZ_W-1:0]      hz_reg;
    logic [STAMP_W-1:0]   last_stamp_reg;
    logic                 primed_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [DELTA_W-1:0]   delta_reg;
    logic                 out_valid_reg;
    logic [DELTA_W-1:0]   out_delta_reg;
    logic [ELAPSED_W-1:0] out_elapsed_reg;
    logic [DELTA_W-1:0]   out_avg_reg;
    logic [RATE_W-1:0]    out_rate_reg;

    logic                 stamp_acc;
    logic [HZ_W-1:0]      hz_eff;
    logic                 conv_start;
    logic [STAMP_W-1:0]   stamp_diff;
    logic [ELAPSED_W:0]   elapsed_sum;
    logic                 out_load;

    conv_rsp_t            conv_rsp;
    ring_req_t            ring_req;
    ring_rsp_t            ring_rsp;
    stats_rsp_t           stats_rsp;

    assign cfg.ready   = 1'b1;
    assign stamp.ready = (state_reg == ST_IDLE);
    assign stamp_acc   = stamp.valid && stamp.ready;

    assign hz_eff     = (hz_reg == '0) ? HZ_W'(1) : hz_reg;
    assign conv_start = stamp_acc && primed_reg;
    assign stamp_diff = stamp.counter_value - last_stamp_reg;

    assign elapsed_sum = {1'b0, elapsed_reg}
                       + {{(ELAPSED_W+1-DELTA_W){1'b0}}, conv_rsp.ns};

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || report.ready);

    ftwm_ns_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .diff  (stamp_diff),
        .hz    (hz_eff),
        .rsp   (conv_rsp)
    );

    // delta_reg is loaded on the same edge the ring starts and is read later
    assign ring_req.start = conv_rsp.done;
    assign ring_req.delta = delta_reg;

    ftwm_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ring_req),
        .rsp   (ring_rsp)
    );

    ftwm_stats u_stats (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ring_rsp.done),
        .sum   (ring_rsp.sum),
        .rsp   (stats_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hz_reg         <= HZ_RESET;
            last_stamp_reg <= '0;
            primed_reg     <= 1'b0;
            elapsed_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                hz_reg <= cfg.counter_hz;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (report.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (stamp_acc)
                    begin
                        last_stamp_reg <= stamp.counter_value;
                        primed_reg     <= 1'b1;
                        if (primed_reg)
                        begin
                            state_reg <= ST_CONV;
                        end
                    end
                end
                ST_CONV:
                begin
                    if (conv_rsp.done)
                    begin
                        elapsed_reg <= elapsed_sum[ELAPSED_W]
                                     ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
                        state_reg   <= ST_RING;
                    end
                end
                ST_RING:
                begin
                    if (ring_rsp.done)
                    begin
                        state_reg <= ST_STATS;
                    end
                end
                ST_STATS:
                begin
                    if (stats_rsp.done)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (conv_rsp.done)
        begin
            delta_reg <= conv_rsp.ns;
        end
        if (out_load)
        begin
            out_delta_reg   <= delta_reg;
            out_elapsed_reg <= elapsed_reg;
            out_avg_reg     <= stats_rsp.avg;
            out_rate_reg    <= stats_rsp.rate;
        end
    end

    assign report.valid          = out_valid_reg;
    assign report.delta_ns       = out_delta_reg;
    assign report.elapsed_ns     = out_elapsed_reg;
    assign report.avg_frame_ns   = out_avg_reg;
    assign report.frame_rate_q16 = out_rate_reg;

    // conv and stats completions only arrive in the phase that waits for them
    a_conv_phase: assert property (@(posedge clk) disable iff (!rst_n)
        conv_rsp.done |-> state_reg == ST_CONV)
        else $error("delta conversion finished outside its phase");

    a_stats_phase: assert property (@(posedge clk) disable iff (!rst_n)
        stats_rsp.done |-> state_reg == ST_STATS)
        else $error("statistics finished outside their phase");

    // elapsed time is saturating and never goes backward
    a_elapsed_mono: assert property (@(posedge clk) disable iff (!rst_n)
        primed_reg |=> elapsed_reg >= $past(elapsed_reg))
        else $error("elapsed time decreased");

    // a finished result never overwrites a report still waiting
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && out_valid_reg && !report.ready
        |=> state_reg == ST_OUT && out_valid_reg)
        else $error("pending report overwritten");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb: frame time window monitor testbench
// Sends counter stamps and counter frequency writes over the channel
// interfaces, keeps its own copy of the delta window and elapsed time, and
// checks every report field by field against the predicted values.
// ============================================================================
module tb;
    import ftwm_pkg::*;

    localparam logic [63:0] NS_PER_SEC    = 64'd1_000_000_000;
    localparam logic [63:0] RATE_SCALE    = NS_PER_SEC * 64'(WINDOW) * 64'd65536;
    localparam int          SETTLE_CYCLES = 160;
    localparam int          RAND_PHASES   = 8;
    localparam int          PHASE_ITEMS   = 230;

    typedef struct {
        logic [DELTA_W-1:0]   delta_ns;
        logic [ELAPSED_W-1:0] elapsed_ns;
        logic [DELTA_W-1:0]   avg_frame_ns;
        logic [RATE_W-1:0]    frame_rate_q16;
    } frame_report_t;

    class frame_stats_scoreboard;
        logic [HZ_W-1:0]      hz;
        logic [STAMP_W-1:0]   prev_stamp;
        bit                   have_ref;
        logic [ELAPSED_W-1:0] elapsed;
        logic [SUM_W-1:0]     win_sum;
        logic [DELTA_W-1:0]   deltas [WINDOW];
        int                   slot;
        frame_report_t        expected_q [$];
        int                   errors;

        function new();
            hz         = HZ_RESET;
            prev_stamp = '0;
            have_ref   = 1'b0;
            elapsed    = '0;
            win_sum    = '0;
            slot       = 0;
            errors     = 0;
            foreach (deltas[k])
                deltas[k] = '0;
        endfunction

        function void set_hz(logic [HZ_W-1:0] value);
            hz = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // one accepted stamp: predict its report, if any
        function void note_stamp(logic [STAMP_W-1:0] stamp);
            logic [63:0]          diff;
            logic [127:0]         ns_full;
            logic [DELTA_W-1:0]   d;
            logic [ELAPSED_W:0]   acc;
            logic [63:0]          rate_full;
            frame_report_t        rep;
            if (!have_ref)
            begin
                prev_stamp = stamp;
                have_ref   = 1'b1;
                return;
            end
            diff       = stamp - prev_stamp;
            prev_stamp = stamp;
            // exact floor(diff * 1e9 / hz); zero frequency counts as one
            ns_full = {64'd0, diff} * {64'd0, NS_PER_SEC};
            ns_full = ns_full / {96'd0, (hz == '0) ? 32'd1 : hz};
            d = (ns_full > {88'd0, DELTA_MAX}) ? DELTA_MAX : ns_full[DELTA_W-1:0];

            acc     = {1'b0, elapsed} + {25'd0, d};
            elapsed = acc[ELAPSED_W] ? ELAPSED_MAX : acc[ELAPSED_W-1:0];

            win_sum      = win_sum - SUM_W'(deltas[slot]) + SUM_W'(d);
            deltas[slot] = d;
            slot         = (slot + 1) % WINDOW;

            if (win_sum == '0)
                rep.frame_rate_q16 = RATE_MAX;
            else
            begin
                rate_full = RATE_SCALE / {{(64-SUM_W){1'b0}}, win_sum};
                rep.frame_rate_q16 = (rate_full > 64'(RATE_MAX)) ? RATE_MAX
                                                                 : rate_full[RATE_W-1:0];
            end
            rep.delta_ns     = d;
            rep.elapsed_ns   = elapsed;
            rep.avg_frame_ns = DELTA_W'(win_sum / SUM_W'(WINDOW));
            expected_q.push_back(rep);
        endfunction

        function void check_report(frame_report_t got);
            frame_report_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected report: delta_ns %0d elapsed_ns %0d",
                       got.delta_ns, got.elapsed_ns);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.delta_ns !== want.delta_ns)
            begin
                $error("delta_ns: expected %0d, actual %0d", want.delta_ns, got.delta_ns);
                errors++;
            end
            if (got.elapsed_ns !== want.elapsed_ns)
            begin
                $error("elapsed_ns: expected %0d, actual %0d",
                       want.elapsed_ns, got.elapsed_ns);
                errors++;
            end
            if (got.avg_frame_ns !== want.avg_frame_ns)
            begin
                $error("avg_frame_ns: expected %0d, actual %0d",
                       want.avg_frame_ns, got.avg_frame_ns);
                errors++;
            end
            if (got.frame_rate_q16 !== want.frame_rate_q16)
            begin
                $error("frame_rate_q16: expected %0h, actual %0h",
                       want.frame_rate_q16, got.frame_rate_q16);
                errors++;
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   steady;

    logic [STAMP_W-1:0]    cur_stamp;
    frame_report_t         seen_report;
    frame_stats_scoreboard sb;

    ftwm_stamp_if  stamp_if ();
    ftwm_report_if report_if ();
    ftwm_cfg_if    cfg_if ();

    frame_time_window_monitor_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .stamp  (stamp_if),
        .report (report_if),
        .cfg    (cfg_if)
    );

    always #2 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 150);
    endfunction

    // handshakes are judged at the falling edge, where all posedge updates have settled
    task automatic send_stamp(input logic [STAMP_W-1:0] value);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            stamp_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cur_stamp = value;
        stamp_if.valid         <= 1'b1;
        stamp_if.counter_value <= value;
        do @(negedge clk); while (!stamp_if.ready);
        @(posedge clk);
        sb.note_stamp(value);
    endtask

    task automatic send_after(input logic [63:0] diff);
        send_stamp(cur_stamp + diff);
    endtask

    task automatic drain_reports();
        stamp_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_hz(input logic [HZ_W-1:0] hz);
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_if.valid      <= 1'b1;
        cfg_if.counter_hz <= hz;
        do @(negedge clk); while (!cfg_if.ready);
        @(posedge clk);
        cfg_if.valid <= 1'b0;
        sb.set_hz(hz);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && report_if.valid && report_if.ready)
        begin
            seen_report.delta_ns       = report_if.delta_ns;
            seen_report.elapsed_ns     = report_if.elapsed_ns;
            seen_report.avg_frame_ns   = report_if.avg_frame_ns;
            seen_report.frame_rate_q16 = report_if.frame_rate_q16;
            sb.check_report(seen_report);
        end
    end

    // report receiver: alternating ready and stall runs, always ready when steady
    initial
    begin
        bit rdy;
        int hold;
        rdy  = 1'b0;
        hold = 0;
        report_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (steady)
            begin
                rdy  = 1'b1;
                hold = 0;
                report_if.ready <= 1'b1;
            end
            else if (hold > 0)
                hold--;
            else
            begin
                rdy  = !rdy;
                hold = rdy ? $urandom_range(0, 30) : pick_gap();
                report_if.ready <= rdy;
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int                r;
        logic [HZ_W-1:0]   hz_sel;
        sb = new();
        steady                 = 1'b0;
        cur_stamp              = '0;
        stamp_if.valid         = 1'b0;
        stamp_if.counter_value = '0;
        cfg_if.valid           = 1'b0;
        cfg_if.counter_hz      = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset frequency: reference stamp, zero delta, wrap, near limit, saturation
        send_stamp(64'hFFFF_FFFF_FFFF_FF00);
        send_after(64'd0);
        send_after(64'h200);
        send_after(64'd10_000_000_000);
        send_after(64'd11_000_000_000);
        send_after(64'h8000_0000_0000_0000);
        send_stamp(64'd0);
        send_stamp(64'hFFFF_FFFF_FFFF_FFFF);

        // zero frequency behaves as 1 Hz
        write_hz(32'd0);
        send_after(64'd1);
        send_after(64'd1099);
        send_after(64'd1100);
        send_after(64'd0);

        write_hz(32'd1);
        send_after(64'hFFFF_FFFF_FFFF_FFFF);
        send_after(64'd3);

        write_hz(32'hFFFF_FFFF);
        send_after(64'd1);
        send_after(64'hFFFF_FFFF);
        send_after({$urandom(), $urandom()});

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0:       hz_sel = $urandom();
                1:       hz_sel = 32'd27_000_000;
                2:       hz_sel = $urandom_range(1, 1000);
                3:       hz_sel = 32'hFFFF_FFFF;
                4:       hz_sel = 32'd0;
                5:       hz_sel = $urandom_range(1_000_000, 1_000_000_000);
                6:       hz_sel = 32'd24_000_000;
                default: hz_sel = $urandom();
            endcase
            write_hz(hz_sel);
            steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 49) == 0)
                    steady = !steady;
                r = $urandom_range(0, 99);
                // mostly plausible frame periods up to ~50 ms
                if (r < 75)
                    send_after(64'($urandom_range(0, hz_sel / 20 + 2)));
                else if (r < 83)
                    send_after(64'd0);
                else if (r < 93)
                    send_stamp({$urandom(), $urandom()});
                else
                    send_after({$urandom(), $urandom()} >> $urandom_range(0, 63));
            end
        end
        steady = 1'b0;

        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ftwm_pkg.sv
rtl/core/ftwm_ifs.sv
rtl/core/ftwm_ns_conv.sv
rtl/core/ftwm_ring.sv
rtl/core/ftwm_stats.sv
rtl/core/frame_time_window_monitor_top.sv
tb/tb.sv
